@@ hdl/tqs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_pkg
// Types and constants shared by the timer queue scheduler.
// ----------------------------------------------------------------------------
package tqs_pkg;
    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int SLOT_W    = $clog2(SLOTS);
    localparam int CNT_W     = 5;
    localparam int MAX_FIRE  = 16;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = $clog2(Q_DEPTH);
    localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TICK   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        EV_CREATED = 2'd0,
        EV_DELETED = 2'd1,
        EV_FIRED   = 2'd2,
        EV_IDLE    = 2'd3
    } t_event;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] delay_ms;
        logic        repeat_on;
        logic [31:0] target_id;
    } t_in;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [1:0]  status;
        logic [31:0] tmr_id;
        logic [4:0]  active_count;
        logic        last;
    } t_out;
endpackage

@@ hdl/tqs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_in_if / tqs_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tqs_in_if import tqs_pkg::*; ();
    logic valid;
    logic ready;
    t_in  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tqs_out_if import tqs_pkg::*; ();
    logic valid;
    logic ready;
    t_out data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tqs_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_front
// Accepts requests, drops unused codes and queues them for the engine.
// ----------------------------------------------------------------------------
module tqs_front import tqs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    tqs_in_if.sink in_ch,
    output logic  o_valid,
    output t_in   o_data,
    input  logic  i_pop
);
    t_in                r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp, r_rp;
    logic [Q_CNT_W-1:0] r_cnt;
    logic               push;

    assign in_ch.ready = (r_cnt != Q_CNT_W'(Q_DEPTH));
    assign push = in_ch.valid && in_ch.ready && (in_ch.data.req_type != REQ_NONE);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= in_ch.data;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (i_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + Q_CNT_W'(push) - Q_CNT_W'(i_pop);
        end
    end
endmodule

@@ hdl/tqs_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tqs_engine
// Slot table and sequencer: scans slots one per cycle to create, delete and
// fire expired timers in deadline order.
// ----------------------------------------------------------------------------
module tqs_engine import tqs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_in   i_data,
    output logic  o_pop,
    tqs_out_if.source out_ch
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_TICK  = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    t_state                r_state;
    logic [SLOTS-1:0]      r_valid, r_done;
    logic [TIME_BITS-1:0]  r_dl [SLOTS];
    logic [31:0]           r_per [SLOTS];
    logic                  r_rep [SLOTS];
    logic [31:0]           r_ser [SLOTS];
    logic [TIME_BITS-1:0]  r_now;
    logic [31:0]           r_next;
    t_in                   r_req;
    logic [SLOT_W:0]       r_idx;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_best;
    logic [TIME_BITS-1:0]  r_bdl;
    logic [31:0]           r_bser;
    logic [CNT_W-1:0]      r_fired;
    logic [CNT_W-1:0]      r_elig;
    logic [CNT_W-1:0]      r_act;
    logic                  r_ov;
    t_out                  r_out;

    logic [SLOT_W-1:0]     idx;
    logic                  better, elig, scan_end, apply_go, fire_last, rescan;
    logic [CNT_W-1:0]      fired_inc;
    t_out                  n_out;

    assign idx = r_idx[SLOT_W-1:0];
    assign scan_end = (r_idx == (SLOT_W+1)'(SLOTS));
    assign elig = r_valid[idx] && !r_done[idx] && (r_dl[idx] <= r_now);
    assign better = !r_found || (r_dl[idx] < r_bdl) ||
                    (r_dl[idx] == r_bdl && r_ser[idx] < r_bser);
    assign apply_go  = (r_state == S_APPLY) && (!r_ov || out_ch.ready);
    assign fired_inc = r_fired + 1'b1;
    // every slot expired at the first pass fires once this tick
    assign fire_last = (fired_inc == r_elig) || (fired_inc == CNT_W'(MAX_FIRE));
    assign rescan    = r_found && (r_req.req_type == REQ_TICK) && !fire_last;

    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign out_ch.valid = r_ov;
    assign out_ch.data  = r_out;

    always_comb begin
        n_out.event_kind   = EV_IDLE;
        n_out.status       = ST_OK;
        n_out.tmr_id       = '0;
        n_out.active_count = r_act;
        n_out.last         = 1'b1;
        unique case (r_req.req_type)
            REQ_CREATE: begin
                n_out.event_kind = EV_CREATED;
                if (r_found) begin
                    n_out.tmr_id       = r_next;
                    n_out.active_count = r_act + 1'b1;
                end else n_out.status = ST_FULL;
            end
            REQ_DELETE: begin
                n_out.event_kind = EV_DELETED;
                n_out.tmr_id     = r_req.target_id;
                if (r_found) n_out.active_count = r_act - 1'b1;
                else n_out.status = ST_NOT_FOUND;
            end
            REQ_TICK: begin
                if (r_found) begin
                    n_out.event_kind = EV_FIRED;
                    n_out.tmr_id     = r_bser;
                    n_out.last       = fire_last;
                    if (!r_rep[r_best]) n_out.active_count = r_act - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= '0; r_now <= '0; r_next <= '0;
            r_ov <= 1'b0; r_act <= '0; r_done <= '0;
        end else begin
            r_ov <= apply_go || (r_ov && !out_ch.ready);
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_data; r_idx <= '0; r_found <= 1'b0;
                        r_done <= '0; r_fired <= '0; r_elig <= '0;
                        if (i_data.req_type == REQ_TICK) begin
                            r_now <= r_now + 1'b1;
                            r_state <= S_TICK;
                        end else r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (scan_end) r_state <= S_APPLY;
                    else begin
                        if (!r_found &&
                            ((r_req.req_type == REQ_CREATE && !r_valid[idx]) ||
                             (r_req.req_type == REQ_DELETE && r_valid[idx] &&
                              r_ser[idx] == r_req.target_id))) begin
                            r_found <= 1'b1; r_best <= idx;
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TICK: begin
                    if (scan_end) r_state <= S_APPLY;
                    else begin
                        if (elig && better) begin
                            r_found <= 1'b1; r_best <= idx;
                            r_bdl <= r_dl[idx]; r_bser <= r_ser[idx];
                        end
                        if (elig && r_fired == '0) r_elig <= r_elig + 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_APPLY: begin
                    if (apply_go) begin
                        r_out <= n_out;
                        r_act <= n_out.active_count;
                        r_state <= rescan ? S_TICK : S_IDLE;
                        if (r_found) begin
                            unique case (r_req.req_type)
                                REQ_CREATE: begin
                                    r_valid[r_best] <= 1'b1;
                                    r_dl[r_best] <= r_now + TIME_BITS'(r_req.delay_ms);
                                    r_per[r_best] <= r_req.delay_ms;
                                    r_rep[r_best] <= r_req.repeat_on;
                                    r_ser[r_best] <= r_next;
                                    r_next <= r_next + 1'b1;
                                end
                                REQ_DELETE: r_valid[r_best] <= 1'b0;
                                REQ_TICK: begin
                                    r_done[r_best] <= 1'b1;
                                    r_fired <= fired_inc;
                                    if (r_rep[r_best])
                                        r_dl[r_best] <= r_bdl + TIME_BITS'(r_per[r_best]);
                                    else r_valid[r_best] <= 1'b0;
                                    if (rescan) begin
                                        r_idx <= '0; r_found <= 1'b0;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/timer_queue_scheduler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// timer_queue_scheduler
// Sixteen-slot millisecond timer table with create, delete and tick.
// ----------------------------------------------------------------------------
// A create or delete request passes through the request queue, a scan of the
// slot table one slot per cycle, and an apply step that registers its result;
// the engine takes the next request only after that apply step, so requests
// are handled one at a time. A tick's first result takes the same path and
// each further fired timer follows once the slot scan has been repeated to
// find each next deadline. A result held by the sink stalls the engine only
// when the next result is ready; a two-entry request queue takes requests
// meanwhile.
module timer_queue_scheduler import tqs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    tqs_in_if.sink    in_ch,
    tqs_out_if.source out_ch
);
    logic q_valid, q_pop;
    t_in  q_data;

    tqs_front u_front (.i_clk, .i_rst_n, .in_ch, .o_valid(q_valid),
                       .o_data(q_data), .i_pop(q_pop));
    tqs_engine u_eng (.i_clk, .i_rst_n, .i_valid(q_valid), .i_data(q_data),
                      .o_pop(q_pop), .out_ch);

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid |-> out_ch.data.active_count <= 5'd16)
        else $error("active count too large");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && !out_ch.ready |=> $stable(out_ch.data))
        else $error("result changed under stall");
    a_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.valid && out_ch.data.event_kind == EV_IDLE |-> out_ch.data.last)
        else $error("idle tick not last");
endmodule
